FILE: design/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, types and helpers of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_WIDTH = 32;                       // Q16.16 coefficient
   localparam int FRAC_BITS  = 16;
   localparam int ROOT_BITS  = 48;                       // Q32.16 root
   localparam int TOL_W      = 16;
   localparam int PROD_W     = 2 * COEF_WIDTH;           // b*b, a*c
   localparam int DISC_W     = PROD_W + 2;               // |b*b - 4ac| magnitude
   localparam int SQRT_W     = DISC_W / 2;               // floor(sqrt(D))
   localparam int SREM_W     = SQRT_W + 3;               // sqrt partial remainder
   localparam int DEN_W      = COEF_WIDTH + 1;           // |2a| or |b|
   localparam int NUM_W      = COEF_WIDTH + 2 + FRAC_BITS; // |(-b -/+ s) << frac|
   localparam int CNT_W      = 2;

   localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
   localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
   localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic signed [ROOT_BITS-1:0]  root_type;

   // sideband carried alongside the square root pipeline
   typedef struct packed {
      logic [CNT_W-1:0] count;
      coef_type         coef_b;
      coef_type         coef_c;
      logic [DEN_W-1:0] den_mag;
      logic             den_neg;
   } sq_side_type;

   // sideband of the first divider
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             neg;
   } dv_side_type;

   function automatic logic [COEF_WIDTH:0] coef_mag(coef_type v);
      logic [COEF_WIDTH:0] e;
      e = {v[COEF_WIDTH-1], v};
      return v[COEF_WIDTH-1] ? (~e + 1'b1) : e;
   endfunction

   // signed magnitude quotient -> saturated root, with overflow flag
   function automatic logic [ROOT_BITS:0] sat_root(logic [NUM_W-1:0] q, logic neg);
      logic [NUM_W-1:0]     lim;
      logic [ROOT_BITS-1:0] r;
      logic                 ovf;
      lim = NUM_W'(1) << (ROOT_BITS - 1);
      if (neg) begin
         ovf = q > lim;
         r   = ovf ? {1'b1, {(ROOT_BITS-1){1'b0}}} : ROOT_BITS'(~q + 1'b1);
      end else begin
         ovf = q >= lim;
         r   = ovf ? {1'b0, {(ROOT_BITS-1){1'b1}}} : q[ROOT_BITS-1:0];
      end
      return {ovf, r};
   endfunction

endpackage

FILE: design/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c for signed Q16.16 coefficients, Q32.16 roots.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, 33 square root stages, 1 numerator stage,
//   50 divider stages and 1 output register.
// Throughput: one transaction per cycle while not stalled by a held response;
//   set by the one-bit-per-stage square root and divider pipelines.
// Reset: synchronous, active high; clears all valid bits and sets
//   zero_tolerance to 0. The datapath registers are not reset.
module quadratic_root_solver_top (
   input  logic         clock,
   input  logic         reset,
   // request: [31:0] coef_a, [63:32] coef_b, [95:64] coef_c
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,
   // response: [1:0] root_count, [49:2] root_first, [97:50] root_second,
   //           [98] overflow, [103:99] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,
   // zero_tolerance register
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);
   import qrs_pkg::*;

   localparam int SQ_SIDE_W = $bits(sq_side_type);
   localparam int DV_SIDE_W = $bits(dv_side_type);

   logic [TOL_W-1:0] tol_ff;

   // global advance: move when the last divider stage is empty or the
   // output register frees up this cycle
   logic en, out_load;

   // front to sqrt
   logic              fr_valid;
   logic [DISC_W-1:0] fr_disc;
   sq_side_type       fr_side;
   // sqrt to numerator stage
   logic              sq_valid;
   logic [SQRT_W-1:0] sq_root;
   logic [SQ_SIDE_W-1:0] sq_side_raw;
   sq_side_type       sq_side;
   // numerator stage
   logic              nv_ff;
   logic [NUM_W-1:0]  n1_in, n2_in, n1_ff, n2_ff;
   logic [DEN_W-1:0]  den_ff;
   dv_side_type       d1_in, d1_ff;
   logic              q2neg_in, q2neg_ff;
   // dividers
   logic              dv1_valid, dv2_valid;
   logic [NUM_W-1:0]  q1, q2;
   logic [DV_SIDE_W-1:0] dv1_side_raw;
   dv_side_type       dv1_side;
   logic              dv2_neg;
   // output register
   logic              out_v_ff;
   logic [CNT_W-1:0]  cnt_in, cnt_ff;
   root_type          r1_in, r2_in, r1_ff, r2_ff;
   logic              ovf_in, ovf_ff;
   logic [ROOT_BITS:0] s1, s2;

   // hold the register; the user must write it only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   assign out_load   = !out_v_ff || rsp_tready;
   assign en         = !dv1_valid || out_load;
   assign req_tready = en;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .coef_a    (coef_type'(req_tdata[31:0])),
      .coef_b    (coef_type'(req_tdata[63:32])),
      .coef_c    (coef_type'(req_tdata[95:64])),
      .tol       (tol_ff),
      .out_valid (fr_valid),
      .out_disc  (fr_disc),
      .out_side  (fr_side)
   );

   qrs_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_rad    (fr_disc),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_raw)
   );
   assign sq_side = sq_side_raw;

   // form numerator magnitudes and quotient signs
   always_comb begin
      logic signed [COEF_WIDTH+3:0] nb, sx, t1, t2;
      logic [COEF_WIDTH+3:0]        m1, m2;
      logic [COEF_WIDTH:0]          cm;
      nb = -{{4{sq_side.coef_b[COEF_WIDTH-1]}}, sq_side.coef_b};
      sx = {{(COEF_WIDTH+4-SQRT_W){1'b0}}, sq_root};
      t1 = nb - sx;
      t2 = nb + sx;
      m1 = t1[COEF_WIDTH+3] ? -t1 : t1;
      m2 = t2[COEF_WIDTH+3] ? -t2 : t2;
      cm = coef_mag(sq_side.coef_c);
      d1_in.count = sq_side.count;
      if (sq_side.count == CNT_ONE) begin
         // linear root -c/b
         n1_in     = {{(NUM_W-FRAC_BITS-COEF_WIDTH-1){1'b0}}, cm, {FRAC_BITS{1'b0}}};
         d1_in.neg = !sq_side.coef_c[COEF_WIDTH-1] ^ sq_side.den_neg;
      end else begin
         n1_in     = {m1[COEF_WIDTH+1:0], {FRAC_BITS{1'b0}}};
         d1_in.neg = t1[COEF_WIDTH+3] ^ sq_side.den_neg;
      end
      n2_in    = {m2[COEF_WIDTH+1:0], {FRAC_BITS{1'b0}}};
      q2neg_in = t2[COEF_WIDTH+3] ^ sq_side.den_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
      end else if (en) begin
         nv_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff    <= n1_in;
         n2_ff    <= n2_in;
         den_ff   <= sq_side.den_mag;
         d1_ff    <= d1_in;
         q2neg_ff <= q2neg_in;
      end
   end

   qrs_div #(.SIDE_W(DV_SIDE_W)) u_div_first (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nv_ff),
      .in_num    (n1_ff),
      .in_den    (den_ff),
      .in_side   (d1_ff),
      .out_valid (dv1_valid),
      .out_quot  (q1),
      .out_side  (dv1_side_raw)
   );
   assign dv1_side = dv1_side_raw;

   qrs_div #(.SIDE_W(1)) u_div_second (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nv_ff),
      .in_num    (n2_ff),
      .in_den    (den_ff),
      .in_side   (q2neg_ff),
      .out_valid (dv2_valid),
      .out_quot  (q2),
      .out_side  (dv2_neg)
   );

   // saturate, and drop the roots that the count does not give
   assign s1 = sat_root(q1, dv1_side.neg);
   assign s2 = sat_root(q2, dv2_neg);

   always_comb begin
      cnt_in = dv1_side.count;
      unique case (dv1_side.count)
         CNT_TWO: begin
            r1_in  = s1[ROOT_BITS-1:0];
            r2_in  = s2[ROOT_BITS-1:0];
            ovf_in = s1[ROOT_BITS] | s2[ROOT_BITS];
         end
         CNT_ONE: begin
            r1_in  = s1[ROOT_BITS-1:0];
            r2_in  = '0;
            ovf_in = s1[ROOT_BITS];
         end
         default: begin
            r1_in  = '0;
            r2_in  = '0;
            ovf_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_load) begin
         out_v_ff <= dv1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         cnt_ff <= cnt_in;
         r1_ff  <= r1_in;
         r2_ff  <= r2_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'b00000, ovf_ff, r2_ff, r1_ff, cnt_ff};

   // both dividers advance in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dv1_valid == dv2_valid)
      else $error("divider valid bits disagree");

   // a response with no roots carries zeros
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && cnt_ff == CNT_NONE |-> r1_ff == '0 && r2_ff == '0 && !ovf_ff)
      else $error("no-root response carries data");

   // a single root leaves the second field clear
   a_one_second: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && cnt_ff == CNT_ONE |-> r2_ff == '0)
      else $error("single-root response has second root");

   // a held response and a full last stage stall the request side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready && dv1_valid |-> !req_tready)
      else $error("request accepted while pipeline is full and stalled");

   // a stalled response keeps its count
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready |=> out_v_ff && $stable(cnt_ff))
      else $error("stalled response changed");

endmodule

FILE: design/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Two stages: coefficient products and zero tests, then discriminant and
// root count.
// ----------------------------------------------------------------------------
module qrs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  qrs_pkg::coef_type        coef_a,
   input  qrs_pkg::coef_type        coef_b,
   input  qrs_pkg::coef_type        coef_c,
   input  logic [qrs_pkg::TOL_W-1:0] tol,
   output logic                     out_valid,
   output logic [qrs_pkg::DISC_W-1:0] out_disc,
   output qrs_pkg::sq_side_type     out_side
);
   import qrs_pkg::*;

   // stage 1
   logic                     v1_ff;
   coef_type                 a_ff, b_ff, c_ff;
   logic signed [PROD_W-1:0] bb_in, ac_in, bb_ff, ac_ff;
   logic                     a_zero_in, b_zero_in, a_zero_ff, b_zero_ff;
   // stage 2
   logic                     v2_ff;
   logic [DISC_W:0]          d_in;
   logic [DISC_W-1:0]        d_ff;
   sq_side_type              side_in, side_ff;
   logic [COEF_WIDTH:0]      am2, bm2;

   assign bb_in     = coef_b * coef_b;
   assign ac_in     = coef_a * coef_c;
   assign a_zero_in = coef_mag(coef_a) <= {{(COEF_WIDTH+1-TOL_W){1'b0}}, tol};
   assign b_zero_in = coef_mag(coef_b) <= {{(COEF_WIDTH+1-TOL_W){1'b0}}, tol};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= coef_a;
         b_ff      <= coef_b;
         c_ff      <= coef_c;
         bb_ff     <= bb_in;
         ac_ff     <= ac_in;
         a_zero_ff <= a_zero_in;
         b_zero_ff <= b_zero_in;
         d_ff      <= d_in[DISC_W-1:0];
         side_ff   <= side_in;
      end
   end

   // b*b - 4ac, exact; top bit is the sign
   assign d_in = {3'b000, bb_ff[PROD_W-2:0]} - {ac_ff[PROD_W-1], ac_ff, 2'b00};
   assign am2  = coef_mag(a_ff);
   assign bm2  = coef_mag(b_ff);

   always_comb begin
      side_in.coef_b = b_ff;
      side_in.coef_c = c_ff;
      if (a_zero_ff) begin
         side_in.count   = b_zero_ff ? CNT_NONE : CNT_ONE;
         side_in.den_mag = bm2;
         side_in.den_neg = b_ff[COEF_WIDTH-1];
      end else begin
         side_in.count   = d_in[DISC_W] ? CNT_NONE : CNT_TWO;
         side_in.den_mag = {am2[COEF_WIDTH-1:0], 1'b0};
         side_in.den_neg = a_ff[COEF_WIDTH-1];
      end
   end

   assign out_valid = v2_ff;
   assign out_disc  = d_ff;
   assign out_side  = side_ff;

endmodule

FILE: design/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [qrs_pkg::DISC_W-1:0] in_rad,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [qrs_pkg::SQRT_W-1:0] out_root,
   output logic [SIDE_W-1:0]          out_side
);
   import qrs_pkg::*;

   logic              v_src    [SQRT_W];
   logic [DISC_W-1:0] rad_src  [SQRT_W];
   logic [SREM_W-1:0] rem_src  [SQRT_W];
   logic [SQRT_W-1:0] root_src [SQRT_W];
   logic [SIDE_W-1:0] side_src [SQRT_W];

   logic              v_ff     [SQRT_W];
   logic [DISC_W-1:0] rad_ff   [SQRT_W];
   logic [SREM_W-1:0] rem_ff   [SQRT_W];
   logic [SQRT_W-1:0] root_ff  [SQRT_W];
   logic [SIDE_W-1:0] side_ff  [SQRT_W];

   logic [SREM_W-1:0] rem_in   [SQRT_W];
   logic [SQRT_W-1:0] root_in  [SQRT_W];

   for (genvar i = 0; i < SQRT_W; i++) begin : g_stage
      logic [SREM_W-1:0] cur, trial;
      logic              ge;

      if (i == 0) begin : g_first
         assign v_src[i]    = in_valid;
         assign rad_src[i]  = in_rad;
         assign rem_src[i]  = '0;
         assign root_src[i] = '0;
         assign side_src[i] = in_side;
      end else begin : g_next
         assign v_src[i]    = v_ff[i-1];
         assign rad_src[i]  = rad_ff[i-1];
         assign rem_src[i]  = rem_ff[i-1];
         assign root_src[i] = root_ff[i-1];
         assign side_src[i] = side_ff[i-1];
      end

      // bring down the next bit pair, try (root << 2) | 1
      assign cur        = {rem_src[i][SREM_W-3:0], rad_src[i][DISC_W-1 -: 2]};
      assign trial      = {1'b0, root_src[i], 2'b01};
      assign ge         = cur >= trial;
      assign rem_in[i]  = ge ? cur - trial : cur;
      assign root_in[i] = {root_src[i][SQRT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= {rad_src[i][DISC_W-3:0], 2'b00};
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid = v_ff[SQRT_W-1];
   assign out_root  = root_ff[SQRT_W-1];
   assign out_side  = side_ff[SQRT_W-1];

endmodule

FILE: design/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [qrs_pkg::NUM_W-1:0] in_num,
   input  logic [qrs_pkg::DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [qrs_pkg::NUM_W-1:0] out_quot,
   output logic [SIDE_W-1:0]         out_side
);
   import qrs_pkg::*;

   logic              v_src    [NUM_W];
   logic [NUM_W-1:0]  nq_src   [NUM_W];
   logic [DEN_W-1:0]  rem_src  [NUM_W];
   logic [DEN_W-1:0]  den_src  [NUM_W];
   logic [SIDE_W-1:0] side_src [NUM_W];

   logic              v_ff     [NUM_W];
   logic [NUM_W-1:0]  nq_ff    [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   logic [DEN_W-1:0]  rem_in   [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W:0] cur, dd, diff;
      logic           ge;

      if (i == 0) begin : g_first
         assign v_src[i]    = in_valid;
         assign nq_src[i]   = in_num;
         assign rem_src[i]  = '0;
         assign den_src[i]  = in_den;
         assign side_src[i] = in_side;
      end else begin : g_next
         assign v_src[i]    = v_ff[i-1];
         assign nq_src[i]   = nq_ff[i-1];
         assign rem_src[i]  = rem_ff[i-1];
         assign den_src[i]  = den_ff[i-1];
         assign side_src[i] = side_ff[i-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign cur       = {rem_src[i], nq_src[i][NUM_W-1]};
      assign dd        = {1'b0, den_src[i]};
      assign ge        = cur >= dd;
      assign diff      = cur - dd;
      assign rem_in[i] = ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[i]   <= {nq_src[i][NUM_W-2:0], ge};
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_src[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

FILE: tb/sv/tb_quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_top
// Streams coefficient sets into the quadratic root solver and predicts each
// root set with an exact integer model, checked field by field in order.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_top;
   import qrs_pkg::*;

   localparam int LATENCY   = 87;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic             overflow;
      root_type         root_second;
      root_type         root_first;
      logic [CNT_W-1:0] root_count;
   } roots_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [15:0]  csr_wdata = '0;

   logic [15:0]  tolerance = '0;     // mirror of zero_tolerance
   roots_type    roots_expected[$];
   int           error_count = 0;
   int           hold_request = 0;   // bumped to ask for one long receiver stall
   int           hold_seen = 0;
   int           hold_cycles = 0;    // long receiver stall when nonzero
   bit           gaps_on = 1'b1;

   quadratic_root_solver_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] coef_a, [63:32] coef_b, [95:64] coef_c
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [1:0] count, [49:2] first, [97:50] second, [98] ovf
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Clamp a wide quotient into Q32.16 and flag overflow.
   function automatic root_type clamp_root(logic signed [127:0] v, ref logic ovf);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< 47) - 1;
      lo = -(128'sd1 <<< 47);
      if (v > hi) begin
         ovf = 1'b1;
         return root_type'(hi);
      end
      if (v < lo) begin
         ovf = 1'b1;
         return root_type'(lo);
      end
      return root_type'(v);
   endfunction

   // floor(sqrt(d)) by binary search over a 35-bit range
   function automatic logic [127:0] floor_sqrt(logic [127:0] d);
      logic [127:0] lo, hi, mid;
      lo = 0;
      hi = 128'd1 << 35;
      while (hi - lo > 1) begin
         mid = lo + ((hi - lo) >> 1);
         if (mid * mid <= d) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic roots_type solve_roots(coef_type a, coef_type b, coef_type c);
      roots_type           r;
      logic signed [127:0] sa, sb, sc, disc, s, den;
      logic [127:0]        tol;
      logic                ovf;
      r   = '0;
      ovf = 1'b0;
      sa  = a;
      sb  = b;
      sc  = c;
      tol = tolerance;
      if ((sa < 0 ? -sa : sa) <= tol) begin
         if ((sb < 0 ? -sb : sb) > tol) begin
            r.root_count = CNT_ONE;
            r.root_first = clamp_root((-sc * 65536) / sb, ovf);
         end
      end else begin
         disc = sb * sb - 4 * sa * sc;
         if (disc >= 0) begin
            s   = floor_sqrt(disc);
            den = 2 * sa;
            r.root_count  = CNT_TWO;
            r.root_first  = clamp_root(((-sb - s) * 65536) / den, ovf);
            r.root_second = clamp_root(((-sb + s) * 65536) / den, ovf);
         end
      end
      r.overflow = ovf;
      return r;
   endfunction

   // Offer one coefficient set; predict at acceptance.
   task automatic send_coefs(coef_type a, coef_type b, coef_type c);
      req_tdata  <= {c, b, a};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      roots_expected.insert(roots_expected.size(), solve_roots(a, b, c));
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (roots_expected.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [15:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      tolerance = value;
   endtask

   function automatic coef_type rand_coef(int range_sel);
      case (range_sel)
         0: return coef_type'($urandom);
         1: return coef_type'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         2: return coef_type'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
         default: return coef_type'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   // Boundaries: extremes, linear, no-root, tolerance edge.
   task automatic test_directed();
      send_coefs(32'sh0001_0000, 32'shFFFD_0000, 32'sh0002_0000); // roots 1, 2
      send_coefs(32'sh0001_0000, 32'sh0, 32'sh0001_0000);         // negative disc
      send_coefs(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000); // double root
      send_coefs(32'sh0, 32'sh0002_0000, 32'sh0004_0000);         // linear
      send_coefs(32'sh0, 32'sh0, 32'sh0004_0000);                 // degenerate
      send_coefs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_coefs(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_coefs(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_coefs(32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh0);         // saturating
      send_coefs(32'sh0000_0001, 32'sh8000_0000, 32'sh1);
      send_coefs(32'sh0, 32'sh0000_0001, 32'sh8000_0000);         // linear saturates
      send_coefs(32'sh0, 32'shFFFF_FFFF, 32'sh7FFF_FFFF);
      send_coefs(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
      write_tolerance(16'hFFFF);
      send_coefs(32'sh0000_FFFF, 32'sh0001_0000, 32'sh0003_0000); // linear by tol
      send_coefs(32'shFFFF_0001, 32'sh0000_FFFF, 32'sh0003_0000); // no roots
      send_coefs(32'sh0001_0000, 32'sh0, 32'shFFFF_0000);         // just above tol
      send_coefs(32'shFFFF_0000, 32'sh0, 32'sh0001_0000);
   endtask

   task automatic test_random(int count, logic [15:0] tol_value);
      write_tolerance(tol_value);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            send_coefs(rand_coef(2) & 32'sh0000_00FF, rand_coef($urandom_range(0, 3)),
                       rand_coef($urandom_range(0, 3)));
         else
            send_coefs(rand_coef($urandom_range(0, 3)), rand_coef($urandom_range(0, 3)),
                       rand_coef($urandom_range(0, 3)));
      end
   endtask

   // Stall the receiver long while the sender keeps offering, then pause the
   // sender until every result has come back.
   task automatic test_backpressure();
      hold_request = hold_request + 1;
      gaps_on      = 1'b0;
      repeat (150) send_coefs(rand_coef(0), rand_coef(1), rand_coef(3));
      gaps_on = 1'b1;
      drain();
   endtask

   // Receiver stall pattern, with an occasional long hold.
   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen   <= hold_request;
         hold_cycles <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (($time / 4000) % 3 == 0) begin
         rsp_tready <= 1'b1;     // stretch with no stalls
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      roots_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = roots_type'(rsp_tdata[98:0]);
         if (roots_expected.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            error_count++;
         end else begin
            want = roots_expected.pop_front();
            if (got.root_count !== want.root_count) begin
               $error("root_count expected %0d actual %0d", want.root_count, got.root_count);
               error_count++;
            end
            if (got.root_first !== want.root_first) begin
               $error("root_first expected %0d actual %0d", want.root_first, got.root_first);
               error_count++;
            end
            if (got.root_second !== want.root_second) begin
               $error("root_second expected %0d actual %0d", want.root_second,
                      got.root_second);
               error_count++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, 16'h0000);
      test_random(250, 16'h0100);
      test_backpressure();
      test_random(250, 16'hFFFF);
      drain();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver_top.sv
tb/sv/tb_quadratic_root_solver_top.sv
